// ===== rtl/core/dtf_pkg.sv =====
`timescale 1ns / 1ps
package dtf_pkg;

  localparam int INT_BITS_DEF = 31;
  localparam int FRAC_BITS_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int PLACE_N = 16;
  localparam int PLACE_IW = $clog2(PLACE_N);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_STRICT = 2'd1;
  localparam logic [1:0] MODE_PREFIX = 2'd2;

  typedef enum logic [2:0] {
    TK_DIGIT = 3'd0,
    TK_SIGN  = 3'd1,
    TK_POINT = 3'd2,
    TK_OTHER = 3'd3,
    TK_TERM  = 3'd4
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic       minus;
    logic [3:0] digit;
  } tok_t;

  // place value after k fraction digits: round(2^F/10), then (p+5)/10 per digit
  function automatic longint unsigned place_value_at(input int k, input int frac_bits);
    longint unsigned p;
    p = ((longint'(1) << frac_bits) + 5) / 10;
    for (int i = 0; i < k; i++) begin
      p = (p + 5) / 10;
    end
    return p;
  endfunction

endpackage

// ===== rtl/core/dtf_front.sv =====
`timescale 1ns / 1ps
module dtf_front import dtf_pkg::*; (
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_character,
  output logic       push_valid,
  input  logic       push_ready,
  output tok_t       push_tok
);

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

  always_comb begin
    push_tok.kind  = TK_OTHER;
    push_tok.minus = (in_character == CH_MINUS);
    push_tok.digit = 4'(in_character - CH_ZERO);
    if (in_character == CH_NUL) begin
      push_tok.kind = TK_TERM;
    end else if (in_character >= CH_ZERO && in_character <= CH_NINE) begin
      push_tok.kind = TK_DIGIT;
    end else if (in_character == CH_PLUS || in_character == CH_MINUS) begin
      push_tok.kind = TK_SIGN;
    end else if (in_character == CH_DOT || in_character == CH_COMMA) begin
      push_tok.kind = TK_POINT;
    end
  end

endmodule

// ===== rtl/core/dtf_queue.sv =====
`timescale 1ns / 1ps
module dtf_queue import dtf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  tok_t push_tok,
  output logic pop_valid,
  input  logic pop_ready,
  output tok_t pop_tok
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tok_t          slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push, pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_tok    = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_tok;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

// ===== rtl/core/dtf_back.sv =====
`timescale 1ns / 1ps
module dtf_back import dtf_pkg::*; #(
  parameter int INT_BITS  = INT_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int VAL_W    = 1 + INT_BITS + FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_wdata,
  input  logic                    pop_valid,
  output logic                    pop_ready,
  input  tok_t                    pop_tok,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] out_value,
  output logic                    out_accepted,
  output logic                    out_saturated
);

  localparam logic [INT_BITS+3:0]  INT_MAX  = (INT_BITS+4)'((64'd1 << INT_BITS) - 64'd1);
  localparam logic [FRAC_BITS+4:0] FRAC_MAX = (FRAC_BITS+5)'((64'd1 << FRAC_BITS) - 64'd1);

  logic [FRAC_BITS-1:0] place_tbl [PLACE_N];

  for (genvar g = 0; g < PLACE_N; g++) begin : g_place
    assign place_tbl[g] = FRAC_BITS'(place_value_at(g, FRAC_BITS));
  end

  logic [1:0]           mode_r;
  logic                 at_start_r, at_start_nxt;
  logic                 neg_r, neg_nxt;
  logic                 seen_point_r, seen_point_nxt;
  logic                 stopped_r, stopped_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [INT_BITS-1:0]  int_r, int_nxt;
  logic [FRAC_BITS-1:0] frac_r, frac_nxt;
  logic [PLACE_IW-1:0]  place_idx_r, place_idx_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [VAL_W-1:0] out_value_r, out_value_nxt;
  logic                    out_acc_r, out_acc_nxt;
  logic                    out_sat_r, out_sat_nxt;

  logic                     parsing, pop, is_term;
  logic [INT_BITS+3:0]      int_sum;
  logic [FRAC_BITS+4:0]     frac_sum;
  logic [VAL_W-1:0]         mag;

  assign parsing   = (mode_r == MODE_STRICT) || (mode_r == MODE_PREFIX);
  assign is_term   = (pop_tok.kind == TK_TERM);
  assign pop_ready = !is_term || !out_valid_r || out_ready;
  assign pop       = pop_valid && pop_ready;

  assign int_sum  = (INT_BITS+4)'({int_r, 3'b000}) + (INT_BITS+4)'({int_r, 1'b0})
                  + (INT_BITS+4)'(pop_tok.digit);
  assign frac_sum = (FRAC_BITS+5)'(frac_r)
                  + (FRAC_BITS+5)'(pop_tok.digit * place_tbl[place_idx_r]);
  assign mag      = {1'b0, int_r, frac_r};

  always_comb begin
    at_start_nxt   = at_start_r;
    neg_nxt        = neg_r;
    seen_point_nxt = seen_point_r;
    stopped_nxt    = stopped_r;
    ovf_nxt        = ovf_r;
    int_nxt        = int_r;
    frac_nxt       = frac_r;
    place_idx_nxt  = place_idx_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_acc_nxt    = out_acc_r;
    out_sat_nxt    = out_sat_r;
    if (pop && is_term) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = '0;
      out_acc_nxt   = 1'b1;
      out_sat_nxt   = 1'b0;
      if (parsing) begin
        if (!stopped_r || mode_r == MODE_PREFIX) begin
          out_value_nxt = neg_r ? -$signed(mag) : $signed(mag);
          out_sat_nxt   = ovf_r;
        end else begin
          out_acc_nxt = 1'b0;
        end
      end
      at_start_nxt   = 1'b1;
      neg_nxt        = 1'b0;
      seen_point_nxt = 1'b0;
      stopped_nxt    = 1'b0;
      ovf_nxt        = 1'b0;
      int_nxt        = '0;
      frac_nxt       = '0;
      place_idx_nxt  = '0;
    end else if (pop && parsing) begin
      at_start_nxt = 1'b0;
      if (!stopped_r) begin
        case (pop_tok.kind)
          TK_DIGIT: begin
            if (!seen_point_r) begin
              if (int_sum > INT_MAX) begin
                int_nxt = '1;
                ovf_nxt = 1'b1;
              end else begin
                int_nxt = int_sum[INT_BITS-1:0];
              end
            end else begin
              frac_nxt = (frac_sum > FRAC_MAX) ? '1 : frac_sum[FRAC_BITS-1:0];
              // table tail is zero, so the index just parks at the end
              if (place_idx_r != PLACE_IW'(PLACE_N - 1)) begin
                place_idx_nxt = place_idx_r + 1'b1;
              end
            end
          end
          TK_SIGN: begin
            if (!at_start_r) begin
              stopped_nxt = 1'b1;
            end else begin
              neg_nxt = pop_tok.minus;
            end
          end
          TK_POINT: begin
            if (seen_point_r) begin
              stopped_nxt = 1'b1;
            end else begin
              seen_point_nxt = 1'b1;
            end
          end
          default: begin
            stopped_nxt = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_STRICT;
      at_start_r   <= 1'b1;
      neg_r        <= 1'b0;
      seen_point_r <= 1'b0;
      stopped_r    <= 1'b0;
      ovf_r        <= 1'b0;
      int_r        <= '0;
      frac_r       <= '0;
      place_idx_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      at_start_r   <= at_start_nxt;
      neg_r        <= neg_nxt;
      seen_point_r <= seen_point_nxt;
      stopped_r    <= stopped_nxt;
      ovf_r        <= ovf_nxt;
      int_r        <= int_nxt;
      frac_r       <= frac_nxt;
      place_idx_r  <= place_idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_acc_r   <= out_acc_nxt;
    out_sat_r   <= out_sat_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_accepted  = out_acc_r;
  assign out_saturated = out_sat_r;

`ifndef SYNTHESIS
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_acc_r |-> out_value_r == '0 && !out_sat_r)
    else $error("rejected line carries a value");
  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    pop && is_term |=> at_start_r && !stopped_r && !seen_point_r && int_r == '0
      && frac_r == '0 && place_idx_r == '0)
    else $error("line state not cleared after terminator");
  a_place_needs_point: assert property (@(posedge clk) disable iff (!rst_n)
    place_idx_r != '0 |-> seen_point_r)
    else $error("fraction place advanced without a point");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !(pop && is_term))
    else $error("result overwritten while stalled");
`endif

endmodule

// ===== rtl/core/decimal_text_to_fixed_point_top.sv =====
`timescale 1ns / 1ps
// Decimal text to signed fixed point (Q INT_BITS.FRAC_BITS).
// Input channel: one character per request on in_valid/in_ready/in_character;
// a zero character ends the line. Result channel: one request per line on
// out_valid/out_ready with out_value, out_accepted and out_saturated.
// cfg_we/cfg_wdata write parse_mode (0 none, 1 strict, 2 prefix; 3 acts as 0);
// write it only while no line is in flight.
// Throughput: one character per cycle, unless a terminator waits behind a
// stalled result. The classifier feeds a two-entry queue, and the parser
// retires one queued character per cycle with a single multiply-by-ten or
// digit-times-place accumulate. A terminator is written into the queue and,
// once the characters ahead of it are consumed, popped by the parser, which
// registers the result that drives out_valid.
// When the receiver stalls, the result holds in the output register while the
// parser keeps consuming characters of the next line; only a second terminator
// waits, and the queue then fills and drops in_ready.
// Reset (rst_n, synchronous, active low) empties the queue and the output,
// clears the line state and sets parse_mode to strict.
module decimal_text_to_fixed_point_top import dtf_pkg::*; #(
  parameter int INT_BITS    = INT_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [1:0]                             cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [7:0]                             in_character,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [INT_BITS+FRAC_BITS:0]     out_value,
  output logic                                   out_accepted,
  output logic                                   out_saturated
);

  logic push_valid, push_ready, pop_valid, pop_ready;
  tok_t push_tok, pop_tok;

  dtf_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_character (in_character),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_tok     (push_tok)
  );

  dtf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_tok   (push_tok),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_tok    (pop_tok)
  );

  dtf_back #(
    .INT_BITS  (INT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_tok       (pop_tok),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value     (out_value),
    .out_accepted  (out_accepted),
    .out_saturated (out_saturated)
  );

endmodule
